// ===== design/klt_pkg.sv =====
package klt_pkg;

	localparam int OFFSET_BITS_DEF = 16;
	localparam int QUEUE_DEPTH_DEF = 4;
	localparam int NKW             = 9;

	localparam logic [4:0] K_INT     = 5'd0;
	localparam logic [4:0] K_FLOAT   = 5'd1;
	localparam logic [4:0] K_IDENT   = 5'd2;
	localparam logic [4:0] K_STRING  = 5'd3;
	localparam logic [4:0] K_KW_BASE = 5'd4;
	localparam logic [4:0] K_NEWLINE = 5'd13;
	localparam logic [4:0] K_EQEQ    = 5'd14;
	localparam logic [4:0] K_EQ      = 5'd15;
	localparam logic [4:0] K_GE      = 5'd16;
	localparam logic [4:0] K_GT      = 5'd17;
	localparam logic [4:0] K_LE      = 5'd18;
	localparam logic [4:0] K_LT      = 5'd19;
	localparam logic [4:0] K_NE      = 5'd20;
	localparam logic [4:0] K_COLON   = 5'd21;
	localparam logic [4:0] K_PLUS    = 5'd22;
	localparam logic [4:0] K_MINUS   = 5'd23;
	localparam logic [4:0] K_STAR    = 5'd24;
	localparam logic [4:0] K_SLASH   = 5'd25;
	localparam logic [4:0] K_PERCENT = 5'd26;
	localparam logic [4:0] K_LPAREN  = 5'd27;
	localparam logic [4:0] K_RPAREN  = 5'd28;
	localparam logic [4:0] K_EOF     = 5'd29;
	localparam logic [4:0] K_BANG    = 5'd30;
	localparam logic [4:0] K_UNEXP   = 5'd31;

	// Keyword text, right-justified: the first character sits highest.
	localparam logic [71:0] KW_TEXT [NKW] = '{
		72'("bruh"), 72'("sus"), 72'("bet"), 72'("drip"), 72'("loop"),
		72'("no_cap"), 72'("cap"), 72'("move_it"), 72'({"calm", "_down"})
	};
	localparam logic [3:0] KW_LEN [NKW] = '{
		4'd4, 4'd3, 4'd3, 4'd4, 4'd4, 4'd6, 4'd3, 4'd7, 4'd9
	};

	typedef struct packed {
		logic [7:0] text_byte;
		logic       end_of_text;
	} in_t;

	typedef struct packed {
		logic [4:0]  token_kind;
		logic [15:0] token_start;
		logic [15:0] token_length;
		logic        last_of_run;
	} out_t;

	typedef struct packed {
		logic [4:0]  kind;
		logic [15:0] start;
		logic [15:0] length;
	} tok_t;

	// Up to two tokens produced by one input byte.
	typedef struct packed {
		logic [1:0]     count;
		tok_t [1:0]     toks;
	} bundle_t;

	typedef struct packed {
		logic valid;
		logic pop;
	} head_ctl_t;

	function automatic logic [8:0] kw_step(input logic [8:0] cand, input logic [3:0] i,
		input logic [7:0] c);
		logic [8:0] r;
		logic [3:0] sh;
		r = cand;
		for (int k = 0; k < NKW; k++) begin
			if (i >= KW_LEN[k]) begin
				r[k] = 1'b0;
			end else begin
				sh = KW_LEN[k] - 4'd1 - i;
				if (KW_TEXT[k][{sh, 3'b000} +: 8] != c) r[k] = 1'b0;
			end
		end
		return r;
	endfunction

	function automatic logic [4:0] kw_kind(input logic [8:0] cand, input logic [3:0] cnt);
		logic [4:0] r;
		r = K_IDENT;
		for (int k = NKW - 1; k >= 0; k--) begin
			if (cand[k] && KW_LEN[k] == cnt) r = K_KW_BASE + 5'(k);
		end
		return r;
	endfunction

endpackage

// ===== design/keyword_lexer_tokenizer_top.sv =====
// Streaming tokenizer: one source byte is taken per cycle whenever the four-entry queue
// (each entry holds the tokens of one byte) has room, and each token leaves on its own
// output transaction, so a byte that releases two tokens makes two output transactions
// while the scanner keeps taking bytes. A token is queued with the byte that ends it; the
// scan-state update per byte is the only loop, and the output port's one token per cycle,
// while tok_ready is high, sets the sustained rate once tokens outnumber bytes. Offsets
// saturate at 2^OFFSET_BITS-1, and end of text (flag or NUL byte) restarts them at zero.
module keyword_lexer_tokenizer_top #(
	parameter int OFFSET_BITS = klt_pkg::OFFSET_BITS_DEF,
	parameter int QUEUE_DEPTH = klt_pkg::QUEUE_DEPTH_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          src_valid,
	output logic          src_ready,
	input  klt_pkg::in_t  src,
	output logic          tok_valid,
	input  logic          tok_ready,
	output klt_pkg::out_t tok
);
	import klt_pkg::*;

	logic      push, full, head_valid;
	bundle_t   bundle, head;
	head_ctl_t ctl;

	assign src_ready = !full;

	klt_front #(.OFFSET_BITS(OFFSET_BITS)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.src_valid (src_valid),
		.src_ready (src_ready),
		.src       (src),
		.push      (push),
		.bundle    (bundle)
	);

	klt_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.din        (bundle),
		.full       (full),
		.head       (head),
		.ctl_in     (ctl),
		.head_valid (head_valid)
	);

	klt_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head       (head),
		.ctl_out    (ctl),
		.tok_valid  (tok_valid),
		.tok_ready  (tok_ready),
		.tok        (tok)
	);

endmodule

// ===== design/klt_front.sv =====
module klt_front #(
	parameter int OFFSET_BITS = klt_pkg::OFFSET_BITS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             src_valid,
	input  logic             src_ready,
	input  klt_pkg::in_t     src,
	output logic             push,
	output klt_pkg::bundle_t bundle
);
	import klt_pkg::*;

	localparam logic [OFFSET_BITS-1:0] POS_MAX = {OFFSET_BITS{1'b1}};

	typedef enum logic [9:0] {
		MODE_IDLE  = 10'b0000000001,
		MODE_INT   = 10'b0000000010,
		MODE_FLOAT = 10'b0000000100,
		MODE_IDENT = 10'b0000001000,
		MODE_STR   = 10'b0000010000,
		MODE_EQ    = 10'b0000100000,
		MODE_GT    = 10'b0001000000,
		MODE_LT    = 10'b0010000000,
		MODE_BANG  = 10'b0100000000,
		MODE_ERR   = 10'b1000000000
	} mode_t;

	mode_t                  mode_q, mode_d;
	logic [OFFSET_BITS-1:0] pos_q, pos_d;
	logic [OFFSET_BITS-1:0] beg_q, beg_d;
	logic [8:0]             cand_q, cand_d;
	logic [3:0]             cnt_q, cnt_d;

	logic [7:0] c;
	logic       endt, go_idle, finish, acc;
	logic       is_dig, is_alp, is_spc;
	logic [1:0] n;
	tok_t       tk [2];
	logic [15:0] span16, p16, beg16;

	function automatic logic [15:0] to16(input logic [OFFSET_BITS-1:0] v);
		logic [31:0] w;
		w = 32'(v);
		return w[15:0];
	endfunction

	function automatic tok_t mk(input logic [4:0] kind, input logic [15:0] start,
		input logic [15:0] len);
		tok_t t;
		t.kind   = kind;
		t.start  = start;
		t.length = len;
		return t;
	endfunction

	assign acc = src_valid && src_ready;
	assign c    = src.text_byte;
	assign endt = src.end_of_text || (c == 8'd0);
	assign is_dig = (c >= "0") && (c <= "9");
	assign is_alp = ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
	assign is_spc = (c == " ") || ((c >= 8'd9) && (c <= 8'd13));
	assign p16    = to16(pos_q);
	assign beg16  = to16(beg_q);
	assign span16 = (pos_q >= beg_q) ? to16(pos_q - beg_q) : 16'd0;

	always_comb begin
		mode_d  = mode_q;
		beg_d   = beg_q;
		cand_d  = cand_q;
		cnt_d   = cnt_q;
		n       = 2'd0;
		tk[0]   = '0;
		tk[1]   = '0;
		go_idle = 1'b0;
		finish  = 1'b0;

		case (mode_q)
			MODE_INT, MODE_FLOAT: begin
				if (!endt && is_dig) begin
					mode_d = mode_q;
				end else if (!endt && c == "." && mode_q == MODE_INT) begin
					mode_d = MODE_FLOAT;
				end else begin
					tk[n[0]] = mk((mode_q == MODE_INT) ? K_INT : K_FLOAT, beg16, span16);
					n = n + 2'd1;
					go_idle = 1'b1;
				end
			end
			MODE_IDENT: begin
				if (!endt && (is_alp || is_dig || c == "_")) begin
					cand_d = kw_step(cand_q, cnt_q, c);
					cnt_d  = (cnt_q == 4'd15) ? cnt_q : cnt_q + 4'd1;
				end else begin
					tk[n[0]] = mk(kw_kind(cand_q, cnt_q), beg16, span16);
					n = n + 2'd1;
					go_idle = 1'b1;
				end
			end
			MODE_STR: begin
				if (endt) begin
					tk[n[0]] = mk(K_STRING, beg16, span16);
					n = n + 2'd1;
					finish = 1'b1;
				end else if (c == "\"") begin
					tk[n[0]] = mk(K_STRING, beg16, span16);
					n = n + 2'd1;
					mode_d = MODE_IDLE;
				end
			end
			MODE_EQ, MODE_GT, MODE_LT, MODE_BANG: begin
				if (!endt && c == "=") begin
					tk[n[0]] = mk((mode_q == MODE_EQ) ? K_EQEQ : (mode_q == MODE_GT) ? K_GE :
						(mode_q == MODE_LT) ? K_LE : K_NE, beg16, 16'd2);
					n = n + 2'd1;
					mode_d = MODE_IDLE;
				end else if (mode_q == MODE_BANG) begin
					tk[n[0]] = mk(K_BANG, beg16, 16'd1);
					n = n + 2'd1;
					mode_d = MODE_ERR;
					finish = endt;
				end else begin
					tk[n[0]] = mk((mode_q == MODE_EQ) ? K_EQ : (mode_q == MODE_GT) ? K_GT : K_LT,
						beg16, 16'd1);
					n = n + 2'd1;
					go_idle = 1'b1;
				end
			end
			MODE_ERR: begin
				finish = endt;
			end
			default: begin
				go_idle = 1'b1;
			end
		endcase

		if (go_idle) begin
			mode_d = MODE_IDLE;
			if (endt) begin
				finish = 1'b1;
			end else begin
				beg_d = pos_q;
				if (is_spc) begin
					if (c == 8'h0A) begin
						tk[n[0]] = mk(K_NEWLINE, p16, 16'd1);
						n = n + 2'd1;
					end
				end else if (is_dig) begin
					mode_d = MODE_INT;
				end else if (is_alp) begin
					mode_d = MODE_IDENT;
					cand_d = kw_step(9'h1FF, 4'd0, c);
					cnt_d  = 4'd1;
				end else begin
					case (c)
						"\"": begin
							mode_d = MODE_STR;
							beg_d  = (pos_q < POS_MAX) ? pos_q + 1'b1 : pos_q;
						end
						"=": mode_d = MODE_EQ;
						">": mode_d = MODE_GT;
						"<": mode_d = MODE_LT;
						"!": mode_d = MODE_BANG;
						":": begin tk[n[0]] = mk(K_COLON, p16, 16'd1);   n = n + 2'd1; end
						"+": begin tk[n[0]] = mk(K_PLUS, p16, 16'd1);    n = n + 2'd1; end
						"-": begin tk[n[0]] = mk(K_MINUS, p16, 16'd1);   n = n + 2'd1; end
						"*": begin tk[n[0]] = mk(K_STAR, p16, 16'd1);    n = n + 2'd1; end
						"/": begin tk[n[0]] = mk(K_SLASH, p16, 16'd1);   n = n + 2'd1; end
						"%": begin tk[n[0]] = mk(K_PERCENT, p16, 16'd1); n = n + 2'd1; end
						"(": begin tk[n[0]] = mk(K_LPAREN, p16, 16'd1);  n = n + 2'd1; end
						")": begin tk[n[0]] = mk(K_RPAREN, p16, 16'd1);  n = n + 2'd1; end
						default: begin tk[n[0]] = mk(K_UNEXP, p16, 16'd1); n = n + 2'd1; end
					endcase
				end
			end
		end

		// The end-of-text token always comes last, and the whole scan state starts afresh.
		if (finish) begin
			tk[n[0]] = mk(K_EOF, p16, 16'd0);
			n = n + 2'd1;
			mode_d = MODE_IDLE;
			beg_d  = '0;
			cand_d = 9'h1FF;
			cnt_d  = 4'd0;
		end

		if (finish) begin
			pos_d = '0;
		end else if (!endt && pos_q < POS_MAX) begin
			pos_d = pos_q + 1'b1;
		end else begin
			pos_d = pos_q;
		end
	end

	assign push          = acc && (n != 2'd0);
	assign bundle.count  = n;
	assign bundle.toks   = {tk[1], tk[0]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_IDLE;
			pos_q  <= '0;
			beg_q  <= '0;
			cand_q <= 9'h1FF;
			cnt_q  <= 4'd0;
		end else if (acc) begin
			mode_q <= mode_d;
			pos_q  <= pos_d;
			beg_q  <= beg_d;
			cand_q <= cand_d;
			cnt_q  <= cnt_d;
		end
	end

endmodule

// ===== design/klt_queue.sv =====
module klt_queue #(
	parameter int DEPTH = klt_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  klt_pkg::bundle_t    din,
	output logic                full,
	output klt_pkg::bundle_t    head,
	input  klt_pkg::head_ctl_t  ctl_in,
	output logic                head_valid
);
	import klt_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	bundle_t       mem_q [DEPTH];
	logic [PW-1:0] wr_q, rd_q;
	logic [CW-1:0] cnt_q;
	logic          pop;

	assign full       = (cnt_q == FULL_CNT);
	assign head_valid = (cnt_q != '0);
	assign head       = mem_q[rd_q];
	assign pop        = ctl_in.pop && ctl_in.valid;

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= din;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= (wr_q == LAST_PTR) ? '0 : wr_q + 1'b1;
			if (pop)  rd_q <= (rd_q == LAST_PTR) ? '0 : rd_q + 1'b1;
			if (push && !pop)      cnt_q <= cnt_q + 1'b1;
			else if (pop && !push) cnt_q <= cnt_q - 1'b1;
		end
	end

endmodule

// ===== design/klt_back.sv =====
module klt_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               head_valid,
	input  klt_pkg::bundle_t   head,
	output klt_pkg::head_ctl_t ctl_out,
	output logic               tok_valid,
	input  logic               tok_ready,
	output klt_pkg::out_t      tok
);
	import klt_pkg::*;

	logic idx_q;
	logic last, acc;
	tok_t cur;

	assign cur  = head.toks[idx_q];
	assign last = idx_q || (head.count == 2'd1);
	assign acc  = tok_valid && tok_ready;

	assign tok_valid        = head_valid;
	assign tok.token_kind   = cur.kind;
	assign tok.token_start  = cur.start;
	assign tok.token_length = cur.length;
	assign tok.last_of_run  = last;

	// The queue entry is released only once its final token has gone.
	assign ctl_out.valid = head_valid;
	assign ctl_out.pop   = acc && last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= 1'b0;
		end else if (acc) begin
			idx_q <= !last;
		end
	end

endmodule
